/* design/mftp_pkg.sv */
// ----------------------------------------------------------------------------
// mftp_pkg
// Types, constants and helpers shared by the track parser modules.
// ----------------------------------------------------------------------------
package mftp_pkg;

  localparam int TICK_W  = 32;
  localparam int ACC_W   = (TICK_W > 32) ? TICK_W : 32;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [7:0] META_BYTE  = 8'hff;
  localparam logic [7:0] SYSEX_BYTE = 8'hf0;
  localparam logic [7:0] ESC_BYTE   = 8'hf7;
  localparam logic [7:0] RT_FIRST   = 8'hf8;
  localparam logic [7:0] DATA_MAX   = 8'h7f;
  localparam logic [7:0] TEMPO_TYPE = 8'h51;
  localparam logic [15:0] BEND_BIAS = 16'd8192;
  localparam logic [3:0] BEND_NIB   = 4'he;

  typedef enum logic [3:0] {
    PH_DELTA, PH_EVENT, PH_DATA1, PH_DATA2, PH_META_TYPE,
    PH_META_LEN, PH_META_DATA, PH_SYSEX_LEN, PH_SYSEX_DATA
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAN  = 2'd0,
    KIND_META  = 2'd1,
    KIND_SYSEX = 2'd2,
    KIND_ERR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NO_CONT = 2'd0,
    ERR_RUNNING = 2'd1,
    ERR_BYTE    = 2'd2
  } err_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        tick_time;
    logic [7:0]         status_byte;
    logic [7:0]         first_data;
    logic [7:0]         second_data;
    logic               bad_data;
    logic signed [15:0] bend_value;
    logic               payload_valid;
    logic               message_end;
    logic               sysex_complete;
    logic [23:0]        tempo_value;
    logic [1:0]         error_code;
  } res_t;

  // one accepted byte: up to three errors in order, then the main result
  typedef struct packed {
    logic [31:0] tick;
    logic [7:0]  c;
    logic [2:0]  err;
    logic        main_vld;
    res_t        main;
  } bundle_t;

  function automatic logic [1:0] data_count(input logic [3:0] nib);
    logic [1:0] n;
    unique case (nib)
      4'h8, 4'h9, 4'ha, 4'hb, 4'he: n = 2'd2;
      4'hc, 4'hd:                   n = 2'd1;
      default:                      n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

/* design/mftp_if.sv */
// ----------------------------------------------------------------------------
// mftp_in_if / mftp_out_if
// Valid/ready channels for track bytes and parsed results.
// ----------------------------------------------------------------------------
interface mftp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;
  modport source (output valid, data_byte, track_start, input ready);
  modport sink (input valid, data_byte, track_start, output ready);
endinterface

interface mftp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [31:0]        tick_time;
  logic [7:0]         status_byte;
  logic [7:0]         first_data;
  logic [7:0]         second_data;
  logic               bad_data;
  logic signed [15:0] bend_value;
  logic               payload_valid;
  logic               message_end;
  logic               sysex_complete;
  logic [23:0]        tempo_value;
  logic [1:0]         error_code;
  modport source (output valid, kind, tick_time, status_byte, first_data, second_data,
                  bad_data, bend_value, payload_valid, message_end, sysex_complete,
                  tempo_value, error_code, input ready);
  modport sink (input valid, kind, tick_time, status_byte, first_data, second_data,
                bad_data, bend_value, payload_valid, message_end, sysex_complete,
                tempo_value, error_code, output ready);
endinterface

/* design/mftp_front.sv */
// ----------------------------------------------------------------------------
// mftp_front
// Parse state machine: one byte a cycle while take is high, emits a bundle of results per byte that yields any.
// ----------------------------------------------------------------------------
module mftp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           c,
  input  logic                 track_start,
  output logic                 push,
  output mftp_pkg::bundle_t    bundle
);

  mftp_pkg::phase_t ph_r, ph_nxt, ph;
  logic [7:0] rs_r, rs_nxt, rs, rs2;
  logic sp_r, sp_nxt, sp;
  logic [mftp_pkg::TICK_W-1:0] tick_r, tick_nxt, tick;
  logic [mftp_pkg::ACC_W-1:0] acc_r, acc_nxt, acc, acc_sh;
  logic [31:0] br_r, br_nxt, br_dec;
  logic [7:0] hfd_r, hfd_nxt, hmt_r, hmt_nxt, leb_r, leb_nxt;
  logic [23:0] tempo_r, tempo_nxt;
  logic [1:0] pidx_r, pidx_nxt;
  logic [2:0] err;
  logic main_vld, running, cpl, fall;
  logic [1:0] need;
  mftp_pkg::res_t m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= mftp_pkg::PH_DELTA;
      rs_r <= '0;
      sp_r <= 1'b0;
      tick_r <= '0;
      acc_r <= '0;
      br_r <= '0;
      hfd_r <= '0;
      hmt_r <= '0;
      leb_r <= '0;
      tempo_r <= '0;
      pidx_r <= '0;
    end else if (take) begin
      ph_r <= ph_nxt;
      rs_r <= rs_nxt;
      sp_r <= sp_nxt;
      tick_r <= tick_nxt;
      acc_r <= acc_nxt;
      br_r <= br_nxt;
      hfd_r <= hfd_nxt;
      hmt_r <= hmt_nxt;
      leb_r <= leb_nxt;
      tempo_r <= tempo_nxt;
      pidx_r <= pidx_nxt;
    end
  end

  always_comb begin
    ph   = track_start ? mftp_pkg::PH_DELTA : ph_r;
    rs   = track_start ? 8'h00 : rs_r;
    sp   = track_start ? 1'b0 : sp_r;
    tick = track_start ? '0 : tick_r;
    acc  = track_start ? '0 : acc_r;
    acc_sh = {acc[mftp_pkg::ACC_W-8:0], c[6:0]};
    br_dec = br_r - 32'd1;
    ph_nxt = ph; rs_nxt = rs; sp_nxt = sp; tick_nxt = tick; acc_nxt = acc;
    br_nxt = br_r; hfd_nxt = hfd_r; hmt_nxt = hmt_r; leb_nxt = leb_r;
    tempo_nxt = tempo_r; pidx_nxt = pidx_r;
    err = 3'b000; main_vld = 1'b0; running = 1'b0; rs2 = rs; need = 2'd0;
    cpl = 1'b0; fall = 1'b0;
    m = '0;
    m.tick_time = 32'(tick);
    unique case (ph)
      mftp_pkg::PH_DELTA: begin
        acc_nxt = mftp_pkg::ACC_W'(acc_sh[mftp_pkg::TICK_W-1:0]);
        if (!c[7]) begin
          tick_nxt = tick + acc_sh[mftp_pkg::TICK_W-1:0];
          acc_nxt = '0;
          ph_nxt = mftp_pkg::PH_EVENT;
        end
      end
      mftp_pkg::PH_EVENT: begin
        err[0] = sp && (c != mftp_pkg::ESC_BYTE);
        if (c < mftp_pkg::RT_FIRST) begin
          if (!c[7]) begin
            err[1] = (rs == 8'h00);
            running = 1'b1;
          end else begin
            rs2 = c;
          end
          rs_nxt = rs2;
          need = mftp_pkg::data_count(rs2[7:4]);
          if (need != 2'd0) begin
            if (!running) begin
              ph_nxt = mftp_pkg::PH_DATA1;
            end else if (need > 2'd1) begin
              hfd_nxt = c;
              ph_nxt = mftp_pkg::PH_DATA2;
            end else begin
              main_vld = 1'b1;
              m.first_data = c;
              ph_nxt = mftp_pkg::PH_DELTA;
            end
          end else begin
            fall = 1'b1;
          end
        end else begin
          fall = 1'b1;
        end
        if (fall) begin
          leb_nxt = c;
          acc_nxt = '0;
          if (c == mftp_pkg::META_BYTE) begin
            ph_nxt = mftp_pkg::PH_META_TYPE;
          end else if (c == mftp_pkg::SYSEX_BYTE || c == mftp_pkg::ESC_BYTE) begin
            hmt_nxt = c;
            ph_nxt = mftp_pkg::PH_SYSEX_LEN;
          end else begin
            err[2] = 1'b1;
            ph_nxt = mftp_pkg::PH_DELTA;
          end
        end
      end
      mftp_pkg::PH_DATA1: begin
        if (mftp_pkg::data_count(rs[7:4]) > 2'd1) begin
          hfd_nxt = c;
          ph_nxt = mftp_pkg::PH_DATA2;
        end else begin
          main_vld = 1'b1;
          m.first_data = c;
          ph_nxt = mftp_pkg::PH_DELTA;
        end
      end
      mftp_pkg::PH_DATA2: begin
        main_vld = 1'b1;
        m.first_data = hfd_r;
        m.second_data = c;
        ph_nxt = mftp_pkg::PH_DELTA;
      end
      mftp_pkg::PH_META_TYPE: begin
        hmt_nxt = c;
        tempo_nxt = '0;
        pidx_nxt = '0;
        acc_nxt = '0;
        ph_nxt = mftp_pkg::PH_META_LEN;
      end
      mftp_pkg::PH_META_LEN, mftp_pkg::PH_SYSEX_LEN: begin
        acc_nxt = mftp_pkg::ACC_W'(acc_sh[31:0]);
        if (!c[7]) begin
          br_nxt = acc_sh[31:0];
          acc_nxt = '0;
          if (acc_sh[31:0] == 32'd0) begin
            main_vld = 1'b1;
            m.message_end = 1'b1;
            ph_nxt = mftp_pkg::PH_DELTA;
          end else if (ph == mftp_pkg::PH_META_LEN) begin
            ph_nxt = mftp_pkg::PH_META_DATA;
          end else begin
            ph_nxt = mftp_pkg::PH_SYSEX_DATA;
          end
        end
      end
      mftp_pkg::PH_META_DATA: begin
        if (pidx_r != 2'd3) begin
          unique case (pidx_r)
            2'd0: tempo_nxt[23:16] = c;
            2'd1: tempo_nxt[15:8] = c;
            default: tempo_nxt[7:0] = c;
          endcase
          pidx_nxt = pidx_r + 2'd1;
        end
        br_nxt = br_dec;
        main_vld = 1'b1;
        m.first_data = c;
        m.payload_valid = 1'b1;
        m.message_end = (br_dec == 32'd0);
        if (br_dec == 32'd0) ph_nxt = mftp_pkg::PH_DELTA;
      end
      mftp_pkg::PH_SYSEX_DATA: begin
        leb_nxt = c;
        br_nxt = br_dec;
        main_vld = 1'b1;
        m.first_data = c;
        m.payload_valid = 1'b1;
        m.message_end = (br_dec == 32'd0);
        if (br_dec == 32'd0) ph_nxt = mftp_pkg::PH_DELTA;
      end
      default: ph_nxt = mftp_pkg::PH_DELTA;
    endcase

    // fill the main result by its kind
    if (ph == mftp_pkg::PH_EVENT || ph == mftp_pkg::PH_DATA1 || ph == mftp_pkg::PH_DATA2) begin
      m.kind = mftp_pkg::KIND_CHAN;
      m.status_byte = rs2;
      m.bad_data = (m.first_data > mftp_pkg::DATA_MAX) || (m.second_data > mftp_pkg::DATA_MAX);
      if (rs2[7:4] == mftp_pkg::BEND_NIB)
        m.bend_value = 16'(m.first_data) + {1'b0, m.second_data, 7'b0} - mftp_pkg::BEND_BIAS;
    end else if (ph == mftp_pkg::PH_META_LEN || ph == mftp_pkg::PH_META_DATA) begin
      m.kind = mftp_pkg::KIND_META;
      m.status_byte = mftp_pkg::META_BYTE;
      m.second_data = hmt_r;
      if (m.message_end && hmt_r == mftp_pkg::TEMPO_TYPE) m.tempo_value = tempo_nxt;
    end else begin
      m.kind = mftp_pkg::KIND_SYSEX;
      m.status_byte = hmt_r;
      if (m.message_end) begin
        if (hmt_r == mftp_pkg::SYSEX_BYTE) begin
          cpl = (leb_nxt == mftp_pkg::ESC_BYTE);
          sp_nxt = !cpl;
        end else begin
          cpl = sp && (leb_nxt == mftp_pkg::ESC_BYTE);
          if (cpl) sp_nxt = 1'b0;
        end
      end
      m.sysex_complete = cpl;
    end
  end

  assign push = take && (main_vld || (err != 3'b000));

  always_comb begin
    bundle = '0;
    bundle.tick = 32'(tick);
    bundle.c = c;
    bundle.err = err;
    bundle.main_vld = main_vld;
    bundle.main = m;
  end

endmodule

/* design/mftp_queue.sv */
// ----------------------------------------------------------------------------
// mftp_queue
// Small bundle queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module mftp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mftp_pkg::bundle_t  wdata,
  output logic               full,
  input  logic               pop,
  output logic               nempty,
  output mftp_pkg::bundle_t  rdata
);

  mftp_pkg::bundle_t mem [mftp_pkg::Q_DEPTH];
  logic [mftp_pkg::Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [mftp_pkg::Q_AW:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (mftp_pkg::Q_AW+1)'(push) - (mftp_pkg::Q_AW+1)'(pop);
  end

  assign full   = (cnt_r == (mftp_pkg::Q_AW+1)'(mftp_pkg::Q_DEPTH));
  assign nempty = (cnt_r != '0);
  assign rdata  = mem[rp_r];

endmodule

/* design/mftp_back.sv */
// ----------------------------------------------------------------------------
// mftp_back
// Result sequencer: unpacks each bundle into words on the output register.
// ----------------------------------------------------------------------------
module mftp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               nempty,
  input  mftp_pkg::bundle_t  head,
  output logic               pop,
  mftp_out_if.source         out_ch
);

  logic [3:0] done_r, done_nxt, rem, sel;
  logic vld_r, vld_nxt, load;
  mftp_pkg::res_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      vld_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_nxt;
  end

  always_comb begin
    rem = {head.main_vld, head.err} & ~done_r;
    sel = rem & (~rem + 4'd1);
    load = nempty && (!vld_r || out_ch.ready);
    pop = load && (rem == sel);
    vld_nxt = load ? 1'b1 : (vld_r && !out_ch.ready);
    done_nxt = done_r;
    if (load) done_nxt = pop ? 4'b0000 : (done_r | sel);
    res_nxt = '0;
    res_nxt.kind = mftp_pkg::KIND_ERR;
    res_nxt.tick_time = head.tick;
    res_nxt.first_data = head.c;
    priority case (1'b1)
      sel[0]: res_nxt.error_code = mftp_pkg::ERR_NO_CONT;
      sel[1]: res_nxt.error_code = mftp_pkg::ERR_RUNNING;
      sel[2]: res_nxt.error_code = mftp_pkg::ERR_BYTE;
      default: res_nxt = head.main;
    endcase
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.tick_time      = res_r.tick_time;
  assign out_ch.status_byte    = res_r.status_byte;
  assign out_ch.first_data     = res_r.first_data;
  assign out_ch.second_data    = res_r.second_data;
  assign out_ch.bad_data       = res_r.bad_data;
  assign out_ch.bend_value     = res_r.bend_value;
  assign out_ch.payload_valid  = res_r.payload_valid;
  assign out_ch.message_end    = res_r.message_end;
  assign out_ch.sysex_complete = res_r.sysex_complete;
  assign out_ch.tempo_value    = res_r.tempo_value;
  assign out_ch.error_code     = res_r.error_code;

endmodule

/* design/midi_file_track_parser_core.sv */
// ----------------------------------------------------------------------------
// midi_file_track_parser_core
// Track body parser: bytes in, channel/meta/sysex/error words out.
// ----------------------------------------------------------------------------
// in_ch carries one track byte per word plus track_start, which clears
// running status, tick time and sysex continuation before that byte.
// out_ch carries one result word each: channel message, meta or sysex
// payload byte, or error report.
// the parser takes a byte every cycle unless the queue is full; a byte
// that yields results puts one bundle into a four-deep queue, and the
// sequencer drains one word per cycle from it into the output register
// while out_ch is ready; words pass the queue, then the output register.
// sustained rate, with out_ch ready, is one byte per cycle while each
// byte gives at most one word; one with more words holds the sequencer.
// reset (rst_n low, synchronous) empties the queue and output register
// and puts the parser back at the delta time.
// when out_ch stalls the queue fills and in_ch.ready drops once full.
// ----------------------------------------------------------------------------
module midi_file_track_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  mftp_in_if.sink    in_ch,
  mftp_out_if.source out_ch
);

  logic take, push, full, nempty, pop;
  mftp_pkg::bundle_t wbundle, head;

  assign in_ch.ready = !full;
  assign take = in_ch.valid && !full;

  mftp_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .c(in_ch.data_byte),
    .track_start(in_ch.track_start), .push(push), .bundle(wbundle)
  );

  mftp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(wbundle), .full(full),
    .pop(pop), .nempty(nempty), .rdata(head)
  );

  mftp_back u_back (
    .clk(clk), .rst_n(rst_n), .nempty(nempty), .head(head), .pop(pop),
    .out_ch(out_ch)
  );

`ifndef SYNTH
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != mftp_pkg::KIND_ERR |-> out_ch.error_code == 2'd0)
    else $error("error code on a non-error word");
  a_tempo: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.message_end |-> out_ch.tempo_value == 24'd0)
    else $error("tempo before message end");
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == mftp_pkg::KIND_CHAN
      |-> !out_ch.payload_valid && !out_ch.message_end)
    else $error("channel word with payload marks");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nempty)
    else $error("pop from empty queue");
`endif

endmodule

/* test/mftp_checker.sv */
// ----------------------------------------------------------------------------
// mftp_checker
// Watches the byte and result channels of the track parser, predicts the
// result words of every accepted byte and compares them in order.
// ----------------------------------------------------------------------------
module mftp_checker (
  input  logic clk,
  input  logic rst_n,
  mftp_in_if   in_ch,
  mftp_out_if  out_ch,
  output int   fails,
  output int   pending
);

  mftp_pkg::phase_t phase;
  logic [7:0]  run_st;
  logic        sx_wait;
  logic [31:0] ticks;
  logic [31:0] vacc;
  logic [31:0] remaining;
  logic [7:0]  held1;
  logic [7:0]  held_type;
  logic [23:0] tempo;
  logic [1:0]  pay_idx;
  logic [7:0]  last_ev;
  mftp_pkg::res_t expected_words[$];

  assign pending = expected_words.size();

  function automatic int unsigned need_of(input logic [7:0] st);
    unique case (st[7:4])
      4'h8, 4'h9, 4'ha, 4'hb, 4'he: return 2;
      4'hc, 4'hd:                   return 1;
      default:                      return 0;
    endcase
  endfunction

  function automatic mftp_pkg::res_t blank(input mftp_pkg::kind_t k);
    mftp_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.tick_time = ticks;
    return r;
  endfunction

  task automatic push_err(input mftp_pkg::err_t code, input logic [7:0] c);
    mftp_pkg::res_t r;
    r = blank(mftp_pkg::KIND_ERR);
    r.first_data = c;
    r.error_code = code;
    expected_words.push_back(r);
  endtask

  task automatic push_chan(input logic [7:0] c1, input logic [7:0] c2);
    mftp_pkg::res_t r;
    int b;
    r = blank(mftp_pkg::KIND_CHAN);
    r.status_byte = run_st;
    r.first_data = c1;
    r.second_data = c2;
    r.bad_data = c1[7] | c2[7];
    if (run_st[7:4] == mftp_pkg::BEND_NIB) begin
      b = int'(c1) + (int'(c2) << 7) - 8192;
      r.bend_value = b[15:0];
    end
    expected_words.push_back(r);
  endtask

  task automatic push_meta(input logic [7:0] c, input logic v, input logic e);
    mftp_pkg::res_t r;
    r = blank(mftp_pkg::KIND_META);
    r.status_byte = mftp_pkg::META_BYTE;
    r.first_data = v ? c : 8'h00;
    r.second_data = held_type;
    r.payload_valid = v;
    r.message_end = e;
    if (e && held_type == mftp_pkg::TEMPO_TYPE) r.tempo_value = tempo;
    expected_words.push_back(r);
  endtask

  task automatic push_sysex(input logic [7:0] c, input logic v, input logic e);
    mftp_pkg::res_t r;
    logic done;
    done = 1'b0;
    if (e) begin
      if (held_type == mftp_pkg::SYSEX_BYTE) begin
        done = (last_ev == mftp_pkg::ESC_BYTE);
        sx_wait = !done;
      end else begin
        done = sx_wait && last_ev == mftp_pkg::ESC_BYTE;
        if (done) sx_wait = 1'b0;
      end
    end
    r = blank(mftp_pkg::KIND_SYSEX);
    r.status_byte = held_type;
    r.first_data = v ? c : 8'h00;
    r.payload_valid = v;
    r.message_end = e;
    r.sysex_complete = done;
    expected_words.push_back(r);
  endtask

  task automatic take_event(input logic [7:0] c);
    logic running;
    int unsigned n;
    if (sx_wait && c != mftp_pkg::ESC_BYTE) push_err(mftp_pkg::ERR_NO_CONT, c);
    if (c < mftp_pkg::RT_FIRST) begin
      if (!c[7]) begin
        if (run_st == 8'h00) push_err(mftp_pkg::ERR_RUNNING, c);
        running = 1'b1;
      end else begin
        run_st = c;
        running = 1'b0;
      end
      n = need_of(run_st);
      if (n != 0) begin
        if (!running) begin
          phase = mftp_pkg::PH_DATA1;
        end else if (n > 1) begin
          held1 = c;
          phase = mftp_pkg::PH_DATA2;
        end else begin
          push_chan(c, 8'h00);
          phase = mftp_pkg::PH_DELTA;
        end
        return;
      end
    end
    last_ev = c;
    vacc = '0;
    if (c == mftp_pkg::META_BYTE) begin
      phase = mftp_pkg::PH_META_TYPE;
    end else if (c == mftp_pkg::SYSEX_BYTE || c == mftp_pkg::ESC_BYTE) begin
      held_type = c;
      phase = mftp_pkg::PH_SYSEX_LEN;
    end else begin
      push_err(mftp_pkg::ERR_BYTE, c);
      phase = mftp_pkg::PH_DELTA;
    end
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic ts);
    if (ts) begin
      run_st = '0;
      ticks = '0;
      sx_wait = 1'b0;
      phase = mftp_pkg::PH_DELTA;
      vacc = '0;
    end
    unique case (phase)
      mftp_pkg::PH_DELTA: begin
        vacc = {vacc[24:0], c[6:0]};
        if (!c[7]) begin
          ticks = ticks + vacc;
          vacc = '0;
          phase = mftp_pkg::PH_EVENT;
        end
      end
      mftp_pkg::PH_EVENT: take_event(c);
      mftp_pkg::PH_DATA1: begin
        if (need_of(run_st) > 1) begin
          held1 = c;
          phase = mftp_pkg::PH_DATA2;
        end else begin
          push_chan(c, 8'h00);
          phase = mftp_pkg::PH_DELTA;
        end
      end
      mftp_pkg::PH_DATA2: begin
        push_chan(held1, c);
        phase = mftp_pkg::PH_DELTA;
      end
      mftp_pkg::PH_META_TYPE: begin
        held_type = c;
        tempo = '0;
        pay_idx = '0;
        vacc = '0;
        phase = mftp_pkg::PH_META_LEN;
      end
      mftp_pkg::PH_META_LEN, mftp_pkg::PH_SYSEX_LEN: begin
        vacc = {vacc[24:0], c[6:0]};
        if (!c[7]) begin
          remaining = vacc;
          vacc = '0;
          if (remaining == 0) begin
            if (phase == mftp_pkg::PH_META_LEN) push_meta(8'h00, 1'b0, 1'b1);
            else push_sysex(8'h00, 1'b0, 1'b1);
            phase = mftp_pkg::PH_DELTA;
          end else begin
            phase = (phase == mftp_pkg::PH_META_LEN) ? mftp_pkg::PH_META_DATA
                                                     : mftp_pkg::PH_SYSEX_DATA;
          end
        end
      end
      mftp_pkg::PH_META_DATA: begin
        if (pay_idx < 2'd3) begin
          tempo = tempo | (24'(c) << (8 * (2 - pay_idx)));
          pay_idx = pay_idx + 2'd1;
        end
        remaining = remaining - 1;
        push_meta(c, 1'b1, remaining == 0);
        if (remaining == 0) phase = mftp_pkg::PH_DELTA;
      end
      mftp_pkg::PH_SYSEX_DATA: begin
        last_ev = c;
        remaining = remaining - 1;
        push_sysex(c, 1'b1, remaining == 0);
        if (remaining == 0) phase = mftp_pkg::PH_DELTA;
      end
      default: phase = mftp_pkg::PH_DELTA;
    endcase
  endtask

  always @(posedge clk) begin
    mftp_pkg::res_t got;
    mftp_pkg::res_t want;
    if (!rst_n) begin
      phase = mftp_pkg::PH_DELTA;
      run_st = '0;
      sx_wait = 1'b0;
      ticks = '0;
      vacc = '0;
      remaining = '0;
      held1 = '0;
      held_type = '0;
      tempo = '0;
      pay_idx = '0;
      last_ev = '0;
      expected_words.delete();
      fails = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.data_byte, in_ch.track_start);
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.tick_time = out_ch.tick_time;
        got.status_byte = out_ch.status_byte;
        got.first_data = out_ch.first_data;
        got.second_data = out_ch.second_data;
        got.bad_data = out_ch.bad_data;
        got.bend_value = out_ch.bend_value;
        got.payload_valid = out_ch.payload_valid;
        got.message_end = out_ch.message_end;
        got.sysex_complete = out_ch.sysex_complete;
        got.tempo_value = out_ch.tempo_value;
        got.error_code = out_ch.error_code;
        if (expected_words.size() == 0) begin
          fails = fails + 1;
          if (fails <= 10) $display("unexpected result word %p", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fails = fails + 1;
            if (fails <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
    end
  end

endmodule

/* test/tb_midi_file_track_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_midi_file_track_parser_core
// Feeds directed and random track bytes (well-formed events mixed with stray
// and broken ones) under random stalls on both sides, then with no stalls;
// the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_midi_file_track_parser_core;

  logic clk;
  logic rst_n;
  logic in_acc;
  int   fails;
  int   pending;
  int   sent;
  int   idle_in;
  int   idle_out;
  logic [7:0] last_st;

  mftp_in_if  in_ch ();
  mftp_out_if out_ch ();

  midi_file_track_parser_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mftp_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) in_acc <= in_ch.valid && in_ch.ready;

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= idle_out);

  task automatic send(input logic [7:0] b, input logic ts);
    while ($urandom_range(99) < idle_in) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.track_start <= ts;
    @(negedge clk);
    while (!in_acc) @(negedge clk);
    sent++;
  endtask

  task automatic send_delta(input logic ts);
    int nb;
    logic [27:0] v;
    if ($urandom_range(99) < 3) begin
      // five bytes, top bits fall off the tick sum
      send(8'h8f | 8'h80, ts);
      repeat (3) send(8'(8'h80 | $urandom_range(127)), 1'b0);
      send(8'($urandom_range(127)), 1'b0);
      return;
    end
    nb = $urandom_range(1, 3);
    v = 28'($urandom);
    for (int i = nb - 1; i > 0; i--) send({1'b1, v[7*i +: 7]}, i == nb - 1 ? ts : 1'b0);
    send({1'b0, v[6:0]}, nb == 1 ? ts : 1'b0);
  endtask

  task automatic send_len(input int n);
    if (n < 128 && $urandom_range(99) < 85) begin
      send(8'(n), 1'b0);
    end else begin
      send(8'(8'h80 | (n >> 7)), 1'b0);
      send(8'(n & 8'h7f), 1'b0);
    end
  endtask

  function automatic logic [7:0] data_val();
    return ($urandom_range(99) < 10) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
  endfunction

  task automatic send_data(input logic [7:0] st);
    unique case (st[7:4])
      4'h8, 4'h9, 4'ha, 4'hb, 4'he: begin
        send(data_val(), 1'b0);
        send(data_val(), 1'b0);
      end
      4'hc, 4'hd: send(data_val(), 1'b0);
      default: ;
    endcase
  endtask

  task automatic rand_event();
    int sel;
    int n;
    logic ts;
    logic [7:0] b;
    ts = ($urandom_range(99) < 3);
    if (ts) last_st = 8'h00;
    send_delta(ts);
    sel = $urandom_range(99);
    if (sel < 35) begin
      last_st = 8'($urandom_range(8'h80, 8'hef));
      send(last_st, 1'b0);
      send_data(last_st);
    end else if (sel < 50) begin
      b = data_val();
      send({1'b0, b[6:0]}, 1'b0);
      if (last_st[7:4] inside {4'h8, 4'h9, 4'ha, 4'hb, 4'he}) send(data_val(), 1'b0);
    end else if (sel < 68) begin
      send(mftp_pkg::META_BYTE, 1'b0);
      send(($urandom_range(99) < 35) ? mftp_pkg::TEMPO_TYPE : 8'($urandom_range(255)), 1'b0);
      n = $urandom_range(0, 5);
      send_len(n);
      repeat (n) send(8'($urandom_range(255)), 1'b0);
    end else if (sel < 86) begin
      send(($urandom_range(1)) ? mftp_pkg::SYSEX_BYTE : mftp_pkg::ESC_BYTE, 1'b0);
      n = $urandom_range(0, 4);
      if ($urandom_range(99) < 3) begin
        // oversized length field that wraps to a small count
        send(8'h90, 1'b0);
        repeat (3) send(8'h80, 1'b0);
        send(8'(n), 1'b0);
      end else begin
        send_len(n);
      end
      for (int i = 0; i < n; i++)
        send((i == n - 1 && $urandom_range(1)) ? mftp_pkg::ESC_BYTE
                                               : 8'($urandom_range(255)), 1'b0);
    end else if (sel < 93) begin
      send(8'($urandom_range(8'hf1, 8'hfe)), 1'b0);
    end else begin
      send(8'($urandom_range(255)), 1'b0);
    end
  endtask

  logic [8:0] directed[] = '{
    9'h100, 9'h090, 9'h03c, 9'h07f,
    9'h000, 9'h03c, 9'h000,
    9'h000, 9'h0e0, 9'h000, 9'h000,
    9'h000, 9'h0ef, 9'h0ff, 9'h0ff,
    9'h000, 9'h0ff, 9'h051, 9'h003, 9'h007, 9'h0a1, 9'h020,
    9'h000, 9'h0f0, 9'h001, 9'h005,
    9'h000, 9'h0f7, 9'h001, 9'h0f7,
    9'h000, 9'h0f4,
    9'h100, 9'h040
  };

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.track_start = 1'b0;
    out_ch.ready = 1'b0;
    idle_in = 31;
    idle_out = 78;
    sent = 0;
    last_st = 8'h00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send(directed[i][7:0], directed[i][8]);
    while (sent < 160) rand_event();
    idle_in = 78;
    idle_out = 31;
    while (sent < 320) rand_event();
    idle_in = 0;
    idle_out = 0;
    while (sent < 475) rand_event();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("** midi_file_track_parser_core: PASSED **");
    end else begin
      $display("** midi_file_track_parser_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** midi_file_track_parser_core: FAILED **");
    $finish;
  end

endmodule
